/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the formatter checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked assertion, also checked during reset
`define ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* sv/bdaf_pkg.sv */
// ----------------------------------------------------------------------------
// bdaf_pkg
// Types, codes, character constants and the digit-extraction helper.
// ----------------------------------------------------------------------------
package bdaf_pkg;

  localparam int VAL_W  = 16;
  localparam int CHAR_W = 8;
  localparam int CMD_W  = 2;

  // Format commands
  localparam logic [CMD_W-1:0] CMD_BYTE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNSIGNED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SIGNED   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ANGLE    = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DEGREE = 8'hDF;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'd44;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  // Angle scaling: tenths of a degree for ninety degrees, and the clamp
  localparam logic [9:0]       ANGLE_SCALE    = 10'd900;
  localparam logic [9:0]       ANGLE_MAX      = 10'd999;
  localparam logic [VAL_W-1:0] ANGLE_FS_RESET = 16'd1023;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Digit weight selectors
  localparam logic [2:0] WIDX_TEN_K   = 3'd0;
  localparam logic [2:0] WIDX_THOU    = 3'd1;
  localparam logic [2:0] WIDX_HUNDRED = 3'd2;
  localparam logic [2:0] WIDX_TEN     = 3'd3;
  localparam logic [2:0] WIDX_ONE     = 3'd4;

  // One print job handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0]  num;
    logic [2:0]        widx;
    logic              has_sign;
    logic [CHAR_W-1:0] sign_ch;
    logic              angle;
  } job_t;

  typedef struct packed {
    logic [3:0]       d;
    logic [VAL_W-1:0] rem;
  } digit_t;

  function automatic logic [16:0] weight(input logic [2:0] widx);
    logic [16:0] w;
    unique case (widx)
      WIDX_TEN_K:   w = 17'd10000;
      WIDX_THOU:    w = 17'd1000;
      WIDX_HUNDRED: w = 17'd100;
      WIDX_TEN:     w = 17'd10;
      default:      w = 17'd1;
    endcase
    return w;
  endfunction

  // Leading digit at the selected weight (clamped to 9) and the remainder
  function automatic digit_t digit_step(input logic [VAL_W-1:0] num,
                                        input logic [2:0] widx);
    logic [16:0] w;
    logic [16:0] m;
    logic [16:0] sub;
    digit_t      r;
    w   = weight(widx);
    sub = '0;
    r.d = '0;
    for (int k = 1; k <= 9; k++) begin
      m = 17'(k) * w;
      if ({1'b0, num} >= m) begin
        r.d = 4'(k);
        sub = m;
      end
    end
    r.rem = num - sub[VAL_W-1:0];
    return r;
  endfunction

endpackage

/* sv/bdaf_if.sv */
// ----------------------------------------------------------------------------
// bdaf_if
// Valid/ready channels: input items, output characters, config writes.
// ----------------------------------------------------------------------------
interface bdaf_in_if import bdaf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [VAL_W-1:0]  value;
  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface bdaf_out_if import bdaf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface bdaf_cfg_if import bdaf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/bdaf_front.sv */
// ----------------------------------------------------------------------------
// bdaf_front
// Accepts items, builds print jobs; angle items go through a multiply and an
// iterative divider (two quotient bits per cycle) before their job is queued.
// ----------------------------------------------------------------------------
module bdaf_front import bdaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [VAL_W-1:0]  in_value,
  input  logic [VAL_W-1:0]  full_scale,
  output logic              q_push,
  output job_t              q_job,
  input  logic              q_full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_CHK  = 3'd2;
  localparam logic [2:0] F_DIV  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  localparam int PROD_W = 26;

  logic [2:0]        st_r, st_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] dsr_r, dsr_nxt;
  logic [9:0]        quo_r, quo_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [9:0]        tenths_r, tenths_nxt;

  logic              accept;
  logic              s1, s2;
  logic [PROD_W-1:0] r1, r2, d2;
  logic [9:0]        q_step;
  job_t              in_job, ang_job;

  assign in_ready = (st_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // Two restoring-division steps per cycle
  always_comb begin
    s1     = rem_r >= dsr_r;
    r1     = s1 ? rem_r - dsr_r : rem_r;
    d2     = dsr_r >> 1;
    s2     = r1 >= d2;
    r2     = s2 ? r1 - d2 : r1;
    q_step = {quo_r[7:0], s1, s2};
  end

  // Job for byte, unsigned and signed items
  always_comb begin
    in_job          = '0;
    in_job.num      = in_value;
    in_job.widx     = WIDX_TEN_K;
    in_job.sign_ch  = CH_SPACE;
    case (in_cmd)
      CMD_BYTE: begin
        in_job.num  = {8'd0, in_value[7:0]};
        in_job.widx = WIDX_HUNDRED;
      end
      CMD_SIGNED: begin
        in_job.has_sign = 1'b1;
        if (in_value[VAL_W-1]) begin
          in_job.sign_ch = CH_MINUS;
          in_job.num     = (~in_value) + 16'd1;
        end else if (in_value == '0) begin
          in_job.sign_ch = CH_SPACE;
        end else begin
          in_job.sign_ch = CH_PLUS;
        end
      end
      default: ;
    endcase
  end

  // Job for an angle item: tenths as three digits with comma and degree
  always_comb begin
    ang_job       = '0;
    ang_job.num   = {6'd0, tenths_r};
    ang_job.widx  = WIDX_HUNDRED;
    ang_job.angle = 1'b1;
    ang_job.sign_ch = CH_SPACE;
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = in_job;
    if (st_r == F_IDLE) begin
      q_push = accept && (in_cmd != CMD_ANGLE);
    end else if (st_r == F_PUSH) begin
      q_push = !q_full;
      q_job  = ang_job;
    end
  end

  // Angle sequencer
  always_comb begin
    st_nxt     = st_r;
    val_nxt    = val_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    dsr_nxt    = dsr_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    tenths_nxt = tenths_r;
    unique case (st_r)
      F_IDLE: begin
        if (accept && (in_cmd == CMD_ANGLE)) begin
          val_nxt = in_value;
          st_nxt  = F_MUL;
        end
      end
      F_MUL: begin
        prod_nxt = {10'd0, val_r} * {16'd0, ANGLE_SCALE};
        st_nxt   = F_CHK;
      end
      F_CHK: begin
        // quotient of 1024 or more (or zero full scale) saturates
        if (prod_r >= {full_scale, 10'd0}) begin
          tenths_nxt = ANGLE_MAX;
          st_nxt     = F_PUSH;
        end else begin
          rem_nxt = prod_r;
          dsr_nxt = {1'b0, full_scale, 9'd0};
          quo_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = r2;
        dsr_nxt = dsr_r >> 2;
        quo_nxt = q_step;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          tenths_nxt = (q_step > ANGLE_MAX) ? ANGLE_MAX : q_step;
          st_nxt     = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) st_nxt = F_IDLE;
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    dsr_r    <= dsr_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    tenths_r <= tenths_nxt;
  end

endmodule

/* sv/bdaf_queue.sv */
// ----------------------------------------------------------------------------
// bdaf_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bdaf_queue import bdaf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = store_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_job;
  end

endmodule

/* sv/bdaf_back.sv */
// ----------------------------------------------------------------------------
// bdaf_back
// Character sequencer: one character per cycle from the queued job unless the
// output stalls, decimal digits peeled off most significant first, into the output register.
// ----------------------------------------------------------------------------
module bdaf_back import bdaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  job_t              q_job,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  localparam logic [1:0] B_SIGN   = 2'd0;
  localparam logic [1:0] B_DIGIT  = 2'd1;
  localparam logic [1:0] B_COMMA  = 2'd2;
  localparam logic [1:0] B_DEGREE = 2'd3;

  logic              act_r, act_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [2:0]        widx_r, widx_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [CHAR_W-1:0] sign_r, sign_nxt;
  logic              angle_r, angle_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  digit_t            ds;
  logic [CHAR_W-1:0] ch;
  logic              last;
  logic [1:0]        st_adv;
  logic [2:0]        widx_adv;
  logic [VAL_W-1:0]  rem_adv;
  logic              adv;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Output slot is free or being emptied
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && (!act_r || last) && !q_empty;

  // Current character and step
  always_comb begin
    ds       = digit_step(rem_r, widx_r);
    ch       = CH_ZERO;
    last     = 1'b0;
    st_adv   = st_r;
    widx_adv = widx_r;
    rem_adv  = rem_r;
    unique case (st_r)
      B_SIGN: begin
        ch     = sign_r;
        st_adv = B_DIGIT;
      end
      B_DIGIT: begin
        ch       = CH_ZERO + {4'd0, ds.d};
        rem_adv  = ds.rem;
        widx_adv = widx_r + 3'd1;
        if (widx_r == WIDX_ONE) begin
          if (angle_r) st_adv = B_DEGREE;
          else last = 1'b1;
        end else if (angle_r && (widx_r == WIDX_TEN)) begin
          st_adv = B_COMMA;
        end
      end
      B_COMMA: begin
        ch     = CH_COMMA;
        st_adv = B_DIGIT;
      end
      B_DEGREE: begin
        ch   = CH_DEGREE;
        last = 1'b1;
      end
      default: last = 1'b1;
    endcase
  end

  always_comb begin
    act_nxt       = act_r;
    st_nxt        = st_r;
    widx_nxt      = widx_r;
    rem_nxt       = rem_r;
    sign_nxt      = sign_r;
    angle_nxt     = angle_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = act_r;
      if (act_r) begin
        out_char_nxt = ch;
        out_last_nxt = last;
        st_nxt       = st_adv;
        widx_nxt     = widx_adv;
        rem_nxt      = rem_adv;
      end
      // load the next job as the current one finishes, or when idle
      if (q_pop) begin
        act_nxt   = 1'b1;
        st_nxt    = q_job.has_sign ? B_SIGN : B_DIGIT;
        widx_nxt  = q_job.widx;
        rem_nxt   = q_job.num;
        sign_nxt  = q_job.sign_ch;
        angle_nxt = q_job.angle;
      end else if (act_r && last) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      st_r        <= B_DIGIT;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r     <= widx_nxt;
    rem_r      <= rem_nxt;
    sign_r     <= sign_nxt;
    angle_r    <= angle_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

/* sv/binary_to_decimal_ascii_formatter_unit.sv */
// Byte, unsigned and signed jobs are queued when their item is taken; an angle
//   item first goes through the multiply, range check and divider.
// Output: one character per cycle unless out_ready stalls it; a number has 3 to 6
//   characters; no new item is taken until an angle item's job is queued.
// Reset (rst_n low, synchronous): queue emptied, output invalid, full scale 1023.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_formatter_unit
// Binary to decimal text formatter: byte, unsigned, signed and angle formats.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_formatter_unit import bdaf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bdaf_in_if.sink     in_ch,
  bdaf_out_if.source  out_ch,
  bdaf_cfg_if.sink    cfg_ch
);

  logic [VAL_W-1:0] full_scale_r, full_scale_nxt;
  logic             q_push, q_pop, q_full, q_empty;
  job_t             push_job, pop_job;

  // Full-scale register, always writable
  assign cfg_ch.ready   = 1'b1;
  assign full_scale_nxt = cfg_ch.valid ? cfg_ch.data : full_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= ANGLE_FS_RESET;
    end else begin
      full_scale_r <= full_scale_nxt;
    end
  end

  bdaf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.command),
    .in_value   (in_ch.value),
    .full_scale (full_scale_r),
    .q_push     (q_push),
    .q_job      (push_job),
    .q_full     (q_full)
  );

  bdaf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  bdaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (pop_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.char_code),
    .out_last  (out_ch.last)
  );

endmodule

/* sv/bdaf_checker.sv */
// ----------------------------------------------------------------------------
// bdaf_checker
// Port-level checks on the formatter output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdaf_checker import bdaf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  logic is_digit;
  logic legal_char;

  assign is_digit   = (out_char >= CH_ZERO) && (out_char <= CH_NINE);
  assign legal_char = is_digit || (out_char == CH_MINUS) || (out_char == CH_PLUS) ||
                      (out_char == CH_SPACE) || (out_char == CH_COMMA) ||
                      (out_char == CH_DEGREE);

  // stalled character stays offered and unchanged
  `ASSERT_CLK(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_hold_data, clk, rst_n, out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))

  // only digits, sign, space, comma and degree sign are ever produced
  `ASSERT_CLK(a_char_set, clk, rst_n, out_valid |-> legal_char)

  // a number ends on a digit or the degree sign, and the degree sign ends it
  `ASSERT_CLK(a_last_char, clk, rst_n, out_valid && (out_last || out_char == CH_DEGREE) |-> (is_digit || out_char == CH_DEGREE) && (out_last || is_digit))

  // nothing offered right after reset
  `ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind binary_to_decimal_ascii_formatter_unit bdaf_checker u_bdaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_code),
  .out_last  (out_ch.last)
);
